// ===== rtl/scpm_pkg.sv =====
// package: shared types and constants of the shunt current and power monitor
package scpm_pkg;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam logic [2:0] ADDR_CFG     = 3'd0;
    localparam logic [2:0] ADDR_SHUNT   = 3'd1;
    localparam logic [2:0] ADDR_BUS     = 3'd2;
    localparam logic [2:0] ADDR_POWER   = 3'd3;
    localparam logic [2:0] ADDR_CURRENT = 3'd4;
    localparam logic [2:0] ADDR_CAL     = 3'd5;

    localparam logic [14:0] CFG_RESET_VALUE = 15'h399F;
    localparam int unsigned CFG_RESET_BIT   = 15;
    localparam logic [15:0] CAL_MASK        = 16'hFFFE;

    // power = floor((x >> 3) * RECIP_M / 2**RECIP_SHIFT), exact for x >> 3 below 2**26
    localparam logic [26:0] RECIP_M     = 27'd109951163;
    localparam int unsigned RECIP_SHIFT = 36;

    typedef struct packed {
        logic accept;
        logic cur;
        logic mul2;
        logic recip;
        logic fin;
        logic load_out;
    } t_scpm_cmd;

endpackage

// ===== rtl/shunt_current_power_monitor.sv =====
// top level: shunt current and power monitor register file
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+------------------------------------------------
//   in      | i_in_valid  | o_in_stall  | i_op, i_reg_addr, i_write_data,
//           |             |             | i_shunt_sample, i_bus_sample
//   out     | o_out_valid | i_out_stall | o_read_data, o_read_valid
//
// one item at a time: a register access goes from accept straight to hand-off, a sample first
// passes the steps signed multiply, divide and saturate, magnitude multiply, reciprocal multiply, update
// each item then waits in a hand-off state until the output register is free
// reset is synchronous and active low; registers return to their power-on values
// a stalled output holds its item; the input stays stalled until the result is handed on
module shunt_current_power_monitor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic [2:0]         i_reg_addr,
    input  logic [15:0]        i_write_data,
    input  logic signed [15:0] i_shunt_sample,
    input  logic [12:0]        i_bus_sample,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_read_data,
    output logic               o_read_valid
);
    import scpm_pkg::*;

    t_scpm_cmd w_cmd;

    scpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    scpm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_op           (i_op),
        .i_reg_addr     (i_reg_addr),
        .i_write_data   (i_write_data),
        .i_shunt_sample (i_shunt_sample),
        .i_bus_sample   (i_bus_sample),
        .o_read_data    (o_read_data),
        .o_read_valid   (o_read_valid)
    );

endmodule

// ===== rtl/scpm_ctrl.sv =====
// controller: sequencing of register accesses, sample arithmetic and result hand-off
module scpm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_op,
    input  logic                i_out_stall,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output scpm_pkg::t_scpm_cmd o_cmd
);
    import scpm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR,
        S_MUL2,
        S_RECIP,
        S_FIN,
        S_PUSH
    } t_state;

    t_state    r_state;
    t_state    n_state;
    logic      r_out_valid;
    t_scpm_cmd w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.accept = 1'b1;
                    n_state      = (t_op'(i_op) == OP_SAMPLE) ? S_CUR : S_PUSH;
                end
            end
            S_CUR: begin
                w_cmd.cur = 1'b1;
                n_state   = S_MUL2;
            end
            S_MUL2: begin
                w_cmd.mul2 = 1'b1;
                n_state    = S_RECIP;
            end
            S_RECIP: begin
                w_cmd.recip = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                w_cmd.fin = 1'b1;
                n_state   = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

// ===== rtl/scpm_dp.sv =====
// datapath: register file, current and power arithmetic, result registers
module scpm_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scpm_pkg::t_scpm_cmd i_cmd,
    input  logic [1:0]          i_op,
    input  logic [2:0]          i_reg_addr,
    input  logic [15:0]         i_write_data,
    input  logic signed [15:0]  i_shunt_sample,
    input  logic [12:0]         i_bus_sample,
    output logic [15:0]         o_read_data,
    output logic                o_read_valid
);
    import scpm_pkg::*;

    logic [14:0]        r_cfg;
    logic [15:0]        r_cal;
    logic [15:0]        r_shunt;
    logic [15:0]        r_bus;
    logic [15:0]        r_pwr;
    logic [15:0]        r_cur;

    logic [12:0]        r_bus_code;
    logic signed [32:0] r_prod1;
    logic [15:0]        r_cur_sat;
    logic [16:0]        r_mag;
    logic               r_ovf;
    logic [29:0]        r_prod2;
    logic [53:0]        r_prod3;

    logic [15:0]        r_res_data;
    logic               r_res_valid;
    logic [15:0]        r_read_data;
    logic               r_read_valid;

    logic [15:0]        w_rd;
    logic signed [32:0] w_biased;
    logic [20:0]        w_q;
    logic               w_pos_sat;
    logic               w_neg_sat;
    logic [15:0]        w_cur;
    logic [16:0]        w_mag;

    always_comb begin
        case (i_reg_addr)
            ADDR_CFG:     w_rd = {1'b0, r_cfg};
            ADDR_SHUNT:   w_rd = r_shunt;
            ADDR_BUS:     w_rd = r_bus;
            ADDR_POWER:   w_rd = r_pwr;
            ADDR_CURRENT: w_rd = r_cur;
            ADDR_CAL:     w_rd = r_cal;
            default:      w_rd = 16'd0;
        endcase
    end

    // divide by 4096 toward zero, then saturate to 16 bits
    assign w_biased  = r_prod1 + (r_prod1[32] ? 33'sd4095 : 33'sd0);
    assign w_q       = w_biased[32:12];
    assign w_pos_sat = !w_q[20] && (|w_q[19:15]);
    assign w_neg_sat = w_q[20] && !(&w_q[19:15]);

    always_comb begin
        if (w_pos_sat) begin
            w_cur = 16'h7FFF;
        end else if (w_neg_sat) begin
            w_cur = 16'h8000;
        end else begin
            w_cur = w_q[15:0];
        end
        if (w_cur[15]) begin
            w_mag = {1'b0, ~w_cur} + 17'd1;
        end else begin
            w_mag = {1'b0, w_cur};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= CFG_RESET_VALUE;
            r_cal   <= 16'd0;
            r_shunt <= 16'd0;
            r_bus   <= 16'd0;
            r_pwr   <= 16'd0;
            r_cur   <= 16'd0;
        end else begin
            if (i_cmd.accept) begin
                case (t_op'(i_op))
                    OP_WRITE: begin
                        if (i_reg_addr == ADDR_CFG) begin
                            if (i_write_data[CFG_RESET_BIT]) begin
                                r_cfg   <= CFG_RESET_VALUE;
                                r_cal   <= 16'd0;
                                r_shunt <= 16'd0;
                                r_bus   <= 16'd0;
                                r_pwr   <= 16'd0;
                                r_cur   <= 16'd0;
                            end else begin
                                r_cfg <= i_write_data[14:0];
                            end
                        end else if (i_reg_addr == ADDR_CAL) begin
                            r_cal <= i_write_data & CAL_MASK;
                        end
                    end
                    OP_READ: begin
                        if (i_reg_addr == ADDR_POWER) begin
                            r_bus[1] <= 1'b0;
                        end
                    end
                    OP_SAMPLE: begin
                        r_shunt <= i_shunt_sample;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.fin) begin
                r_cur <= r_cur_sat;
                r_pwr <= r_prod3[RECIP_SHIFT+15:RECIP_SHIFT];
                r_bus <= {r_bus_code, 1'b0, 1'b1, r_ovf};
            end
        end
    end

    // arithmetic pipeline and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_bus_code  <= i_bus_sample;
            r_prod1     <= 33'(i_shunt_sample) * 33'($signed({1'b0, r_cal}));
            r_res_data  <= (t_op'(i_op) == OP_READ) ? w_rd : 16'd0;
            r_res_valid <= (t_op'(i_op) == OP_READ);
        end
        if (i_cmd.cur) begin
            r_cur_sat <= w_cur;
            r_mag     <= w_mag;
            r_ovf     <= w_pos_sat || w_neg_sat;
        end
        if (i_cmd.mul2) begin
            r_prod2 <= 30'(r_mag) * 30'(r_bus_code);
        end
        if (i_cmd.recip) begin
            r_prod3 <= 54'(r_prod2[29:3]) * 54'(RECIP_M);
        end
        if (i_cmd.load_out) begin
            r_read_data  <= r_res_data;
            r_read_valid <= r_res_valid;
        end
    end

    assign o_read_data  = r_read_data;
    assign o_read_valid = r_read_valid;

endmodule

// ===== dv/tb.sv =====
// testbench: shunt current and power monitor register file, self-checking with a register model
`timescale 1ns / 100ps

module tb;
    import scpm_pkg::*;

    localparam logic [2:0] ADDR_SPARE_LO = 3'd6;
    localparam logic [2:0] ADDR_SPARE_HI = 3'd7;
    localparam longint CURRENT_DIV = 4096;
    localparam longint POWER_DIV   = 5000;
    localparam int     N_RANDOM    = 2000;

    typedef struct {
        t_op               op;
        logic [2:0]        addr;
        logic [15:0]       wdata;
        logic signed [15:0] shunt;
        logic [12:0]       bus;
        bit                drain;
    } t_access;

    typedef struct {
        logic [15:0] data;
        logic        valid;
    } t_answer;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         in_op = 2'd0;
    logic [2:0]         in_addr = 3'd0;
    logic [15:0]        in_wdata = 16'd0;
    logic signed [15:0] in_shunt = 16'sd0;
    logic [12:0]        in_bus = 13'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [15:0]        out_data;
    logic               out_rvalid;

    t_access pending[$];
    t_answer expected_answers[$];
    t_access cur_access;

    logic [14:0] cfg_reg;
    logic [15:0] cal_reg, shunt_reg, bus_reg, power_reg, current_reg;

    int  n_accepted = 0, n_results = 0, n_errors = 0;
    int  n_writes = 0, n_reads = 0, n_samples = 0, n_sat = 0, n_idle_ops = 0;
    int  gap_left = 0, stall_left = 0, hold_left = 0;
    bit  hold_done = 0;
    bit  calm = 0;

    shunt_current_power_monitor uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_op           (in_op),
        .i_reg_addr     (in_addr),
        .i_write_data   (in_wdata),
        .i_shunt_sample (in_shunt),
        .i_bus_sample   (in_bus),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_read_data    (out_data),
        .o_read_valid   (out_rvalid)
    );

    always #5 clk = ~clk;

    task automatic clear_registers();
        cfg_reg     = CFG_RESET_VALUE;
        cal_reg     = '0;
        shunt_reg   = '0;
        bus_reg     = '0;
        power_reg   = '0;
        current_reg = '0;
    endtask

    // register file behaviour for one accepted item, queues the answer it gives
    task automatic predict_register_file(input t_access a);
        t_answer ans;
        longint  cur, mag, pwr;
        logic    ovf;
        ans.data  = '0;
        ans.valid = 1'b0;
        case (a.op)
            OP_WRITE: begin
                n_writes++;
                if (a.addr == ADDR_CFG) begin
                    if (a.wdata[CFG_RESET_BIT]) clear_registers();
                    else cfg_reg = a.wdata[14:0];
                end else if (a.addr == ADDR_CAL) begin
                    cal_reg = a.wdata & CAL_MASK;
                end
            end
            OP_READ: begin
                n_reads++;
                ans.valid = 1'b1;
                case (a.addr)
                    ADDR_CFG:     ans.data = {1'b0, cfg_reg};
                    ADDR_SHUNT:   ans.data = shunt_reg;
                    ADDR_BUS:     ans.data = bus_reg;
                    ADDR_POWER: begin
                        ans.data   = power_reg;
                        bus_reg[1] = 1'b0;
                    end
                    ADDR_CURRENT: ans.data = current_reg;
                    ADDR_CAL:     ans.data = cal_reg;
                    default:      ans.data = '0;
                endcase
            end
            OP_SAMPLE: begin
                n_samples++;
                ovf = 1'b0;
                shunt_reg = a.shunt;
                cur = (longint'(a.shunt) * longint'(cal_reg)) / CURRENT_DIV;
                if (cur > 32767) begin
                    cur = 32767;
                    ovf = 1'b1;
                end
                if (cur < -32768) begin
                    cur = -32768;
                    ovf = 1'b1;
                end
                current_reg = 16'(cur);
                mag = (cur < 0) ? -cur : cur;
                pwr = (mag * longint'(a.bus)) / POWER_DIV;
                if (pwr > 65535) begin
                    pwr = 65535;
                    ovf = 1'b1;
                end
                power_reg = 16'(pwr);
                bus_reg   = {a.bus, 1'b0, 1'b1, ovf};
                if (ovf) n_sat++;
            end
            default: n_idle_ops++;
        endcase
        expected_answers.push_back(ans);
    endtask

    task automatic push_item(input t_op op, input logic [2:0] addr, input logic [15:0] wdata,
                             input logic [15:0] shunt, input logic [12:0] bus);
        t_access a;
        a.op    = op;
        a.addr  = addr;
        a.wdata = wdata;
        a.shunt = shunt;
        a.bus   = bus;
        a.drain = (pending.size() % 250 == 249);
        pending.push_back(a);
    endtask

    // sender
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            clear_registers();
        end else begin
            calm = (pending.size() < 200);
            if (in_valid && !in_stall) begin
                predict_register_file(cur_access);
                n_accepted++;
                if (!calm && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 7);
            end
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending.size() != 0 &&
                             (!pending[0].drain || n_results == n_accepted)) begin
                    cur_access = pending.pop_front();
                    in_valid <= 1'b1;
                    in_op    <= cur_access.op;
                    in_addr  <= cur_access.addr;
                    in_wdata <= cur_access.wdata;
                    in_shunt <= cur_access.shunt;
                    in_bus   <= cur_access.bus;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk) begin
        t_answer exp_ans;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                n_results++;
                if (expected_answers.size() == 0) begin
                    $error("unexpected item: read_data %h read_valid %b", out_data, out_rvalid);
                    n_errors++;
                end else begin
                    exp_ans = expected_answers.pop_front();
                    if (out_data !== exp_ans.data) begin
                        $error("read_data: expected %h, got %h", exp_ans.data, out_data);
                        n_errors++;
                    end
                    if (out_rvalid !== exp_ans.valid) begin
                        $error("read_valid: expected %b, got %b", exp_ans.valid, out_rvalid);
                        n_errors++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!hold_done && n_results >= 300) begin
                hold_done = 1;
                hold_left = 99;
                out_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int sv;
        int n_smp;
        int n_rd;

        // saturation both ways, ready flag, read-only and spare addresses, config reset
        push_item(OP_READ, ADDR_CFG, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_WRITE, ADDR_CAL, 16'hFFFF, 16'h0000, 13'h0000);
        push_item(OP_READ, ADDR_CAL, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_SAMPLE, ADDR_CFG, 16'h0000, 16'h7FFF, 13'h1FFF);
        push_item(OP_READ, ADDR_BUS, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_READ, ADDR_CURRENT, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_READ, ADDR_POWER, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_READ, ADDR_BUS, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_SAMPLE, ADDR_CFG, 16'h0000, 16'h8000, 13'h0000);
        push_item(OP_READ, ADDR_CURRENT, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_READ, ADDR_BUS, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_WRITE, ADDR_CAL, 16'h1000, 16'h0000, 13'h0000);
        push_item(OP_SAMPLE, ADDR_CFG, 16'h0000, 16'hFFFF, 13'h1FFF);
        push_item(OP_READ, ADDR_CURRENT, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_READ, ADDR_POWER, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_SAMPLE, ADDR_CFG, 16'h0000, 16'h0001, 13'h0001);
        push_item(OP_READ, ADDR_BUS, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_WRITE, ADDR_SHUNT, 16'hFFFF, 16'h0000, 13'h0000);
        push_item(OP_WRITE, ADDR_BUS, 16'hFFFF, 16'h0000, 13'h0000);
        push_item(OP_WRITE, ADDR_POWER, 16'hFFFF, 16'h0000, 13'h0000);
        push_item(OP_WRITE, ADDR_CURRENT, 16'hFFFF, 16'h0000, 13'h0000);
        push_item(OP_WRITE, ADDR_SPARE_HI, 16'hFFFF, 16'h0000, 13'h0000);
        push_item(OP_READ, ADDR_SHUNT, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_READ, ADDR_SPARE_LO, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_NONE, ADDR_SPARE_HI, 16'hFFFF, 16'hFFFF, 13'h1FFF);
        push_item(OP_WRITE, ADDR_CFG, 16'h7FFF, 16'h0000, 13'h0000);
        push_item(OP_READ, ADDR_CFG, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_WRITE, ADDR_CFG, 16'hFFFF, 16'h0000, 13'h0000);
        push_item(OP_READ, ADDR_CAL, 16'h0000, 16'h0000, 13'h0000);
        push_item(OP_READ, ADDR_CFG, 16'h0000, 16'h0000, 13'h0000);

        // mostly calibrate, convert, read back; some noise in between
        while (pending.size() < N_RANDOM + 30) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 2) == 0) begin
                    case ($urandom_range(0, 2))
                        0: push_item(OP_WRITE, ADDR_CAL, 16'($urandom), 16'($urandom),
                                     13'($urandom));
                        1: push_item(OP_WRITE, ADDR_CAL, 16'($urandom_range(0, 8192)),
                                     16'($urandom), 13'($urandom));
                        default: push_item(OP_WRITE, ADDR_CFG, {1'b0, 15'($urandom)},
                                           16'($urandom), 13'($urandom));
                    endcase
                end
                n_smp = $urandom_range(1, 3);
                for (int s = 0; s < n_smp; s++) begin
                    case ($urandom_range(0, 3))
                        0, 1: sv = $urandom;
                        2: sv = int'($urandom_range(0, 600)) - 300;
                        default: sv = $urandom_range(0, 1) ? 32'h7FFF : 32'h8000;
                    endcase
                    push_item(OP_SAMPLE, 3'($urandom), 16'($urandom), 16'(sv),
                              $urandom_range(0, 1) ? 13'($urandom) : 13'($urandom_range(0, 40)));
                    n_rd = $urandom_range(0, 3);
                    for (int r = 0; r < n_rd; r++) begin
                        push_item(OP_READ, 3'($urandom_range(0, 5)), 16'($urandom),
                                  16'($urandom), 13'($urandom));
                    end
                end
            end else begin
                push_item(t_op'($urandom_range(0, 3)), 3'($urandom), 16'($urandom),
                          16'($urandom), 13'($urandom));
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending.size() != 0 || in_valid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d writes, %0d reads, %0d samples (%0d saturating), %0d idle ops",
                 n_writes, n_reads, n_samples, n_sat, n_idle_ops);
        $display("%0d results checked with random idling, a long output hold and drains",
                 n_results);
        if (n_errors == 0 && expected_answers.size() == 0) begin
            $display("shunt_current_power_monitor regression: pass");
        end else begin
            $display("shunt_current_power_monitor regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("shunt_current_power_monitor regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/scpm_pkg.sv
rtl/scpm_ctrl.sv
rtl/scpm_dp.sv
rtl/shunt_current_power_monitor.sv
dv/tb.sv
